// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the open reading frame finder RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every clock edge except while reset is asserted.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(label, clk, rst, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/orf_pkg.sv =====
// Types and constants of the open reading frame finder.
// No dependencies; used by every module of the block.
package orf_pkg;

  localparam int POS_W = 21;
  localparam int CNT_W = 19;
  localparam int CFG_W = 64;
  localparam int CFG_IDX_W = 2;

  // Position counter stops here; later bases share this position.
  localparam logic [POS_W-1:0] MAX_BASES = 21'd1048576;
  localparam logic [CNT_W-1:0] COUNT_MAX = 19'd524287;

  // Register reset values: frame grouping from base 1, ATG start, TAA/TAG/TGA stop.
  localparam logic [POS_W-1:0] FRAME_START_RESET = 21'd1;
  localparam logic [CFG_W-1:0] START_MASK_RESET = 64'd16384;
  localparam logic [CFG_W-1:0] STOP_MASK_RESET = 64'd73464968921481216;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_START = 2'd0,
    CFG_START_MASK  = 2'd1,
    CFG_STOP_MASK   = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0] base;
    logic       last;
  } orf_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] length_codons;
    logic [POS_W-1:0] start_pos;
  } orf_result_t;

  typedef struct packed {
    logic        valid;
    orf_result_t result;
  } orf_emit_t;

endpackage

// ===== hw/rtl/orf_in_stage.sv =====
// Input register of the open reading frame finder.
// Depends on orf_pkg for the item type.
module orf_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  orf_pkg::orf_item_t  in_item,
  input  logic                advance,
  output logic                held_valid,
  output orf_pkg::orf_item_t  held_item
);

  // The held word moves on whenever the result side has room.
  assign in_ready = !held_valid || advance;

  // Valid bit of the held word.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload of the held word.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== hw/rtl/orf_tracker.sv =====
// Codon grouping, start/stop matching and frame counting, plus the config registers.
// Depends on orf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module orf_tracker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [orf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [orf_pkg::CFG_W-1:0]             cfg_wdata,
  input  logic                                  step,
  input  orf_pkg::orf_item_t                    item,
  output orf_pkg::orf_emit_t                    emit
);

  logic [orf_pkg::POS_W-1:0] frame_start;
  logic [orf_pkg::CFG_W-1:0] start_mask;
  logic [orf_pkg::CFG_W-1:0] stop_mask;

  logic [orf_pkg::POS_W-1:0] pos, pos_next;
  orf_pkg::phase_t           phase, phase_next;
  logic [3:0]                codon_bits, codon_bits_next;
  logic                      frame_open, frame_open_next;
  logic                      finished, finished_next;
  logic [orf_pkg::POS_W-1:0] open_start, open_start_next;
  logic [orf_pkg::CNT_W-1:0] count, count_next;

  logic [5:0] idx;
  logic       active;
  logic       close;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_start <= orf_pkg::FRAME_START_RESET;
      start_mask  <= orf_pkg::START_MASK_RESET;
      stop_mask   <= orf_pkg::STOP_MASK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        orf_pkg::CFG_FRAME_START: frame_start <= cfg_wdata[orf_pkg::POS_W-1:0];
        orf_pkg::CFG_START_MASK:  start_mask  <= cfg_wdata;
        orf_pkg::CFG_STOP_MASK:   stop_mask   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state and result for the word at hand.
  always_comb begin
    pos_next        = pos;
    phase_next      = phase;
    codon_bits_next = codon_bits;
    frame_open_next = frame_open;
    finished_next   = finished;
    open_start_next = open_start;
    count_next      = count;
    close           = 1'b0;
    idx             = {codon_bits, item.base};
    active          = !finished && (pos >= frame_start);

    if (active) begin
      case (phase)
        orf_pkg::PH_FIRST: begin
          // First base of a codon; remember where it began while searching.
          if (!frame_open) begin
            open_start_next = pos;
          end
          codon_bits_next = {2'b00, item.base};
          phase_next      = orf_pkg::PH_SECOND;
        end
        orf_pkg::PH_SECOND: begin
          codon_bits_next = {codon_bits[1:0], item.base};
          phase_next      = orf_pkg::PH_THIRD;
        end
        default: begin
          // Codon complete: look it up in the start or the stop mask.
          phase_next      = orf_pkg::PH_FIRST;
          codon_bits_next = 4'd0;
          if (!frame_open) begin
            if (start_mask[idx]) begin
              frame_open_next = 1'b1;
              count_next      = orf_pkg::CNT_W'(1);
            end
          end else begin
            if (count < orf_pkg::COUNT_MAX) begin
              count_next = count + orf_pkg::CNT_W'(1);
            end
            if (stop_mask[idx]) begin
              finished_next = 1'b1;
              close         = 1'b1;
            end
          end
        end
      endcase
    end

    // Position saturates at the top of the range.
    if (pos < orf_pkg::MAX_BASES) begin
      pos_next = pos + orf_pkg::POS_W'(1);
    end

    // A closed frame reports itself; the last base reports zeros if no frame was closed.
    emit.valid                = close || (item.last && !finished_next);
    emit.result.start_pos     = close ? open_start : '0;
    emit.result.length_codons = close ? count_next : '0;

    // End of sequence rearms the tracker.
    if (item.last) begin
      pos_next        = orf_pkg::FRAME_START_RESET;
      phase_next      = orf_pkg::PH_FIRST;
      codon_bits_next = 4'd0;
      frame_open_next = 1'b0;
      finished_next   = 1'b0;
      open_start_next = '0;
      count_next      = '0;
    end
  end

  // Tracking state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= orf_pkg::FRAME_START_RESET;
      phase      <= orf_pkg::PH_FIRST;
      codon_bits <= 4'd0;
      frame_open <= 1'b0;
      finished   <= 1'b0;
      open_start <= '0;
      count      <= '0;
    end else if (step) begin
      pos        <= pos_next;
      phase      <= phase_next;
      codon_bits <= codon_bits_next;
      frame_open <= frame_open_next;
      finished   <= finished_next;
      open_start <= open_start_next;
      count      <= count_next;
    end
  end

  // A frame can only be finished after it was opened.
  `ASSERT_CLK_RST(a_finished_needs_open, clk, rst, finished |-> frame_open, "finished without frame")
  // An open frame always holds at least its start codon.
  `ASSERT_CLK_RST(a_open_count_nonzero, clk, rst, frame_open |-> (count != '0), "open frame with zero count")
  // A zero result is only given on the last base.
  `ASSERT_CLK_RST(a_zero_only_on_last, clk, rst, (emit.valid && !close) |-> item.last, "zero result off last")

endmodule

// ===== hw/rtl/orf_out_stage.sv =====
// Result register of the open reading frame finder.
// Depends on orf_pkg for the result type.
module orf_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  orf_pkg::orf_result_t load_result,
  output logic                 out_valid,
  input  logic                 out_ready,
  output orf_pkg::orf_result_t out_result,
  output logic                 room
);

  // The slot is free when empty or being taken this cycle.
  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && room) begin
      out_result <= load_result;
    end
  end

endmodule

// ===== hw/rtl/open_reading_frame_finder_core.sv =====
// Usage:
// Input stream (s_*): one nucleotide word per beat, tdata[1:0] = base
// (A 0, C 1, G 2, T 3), tlast on the final base of a sequence.
// Output stream (m_*): at most one word per sequence: the 1-based start
// position of the first open reading frame and its length in codons, start
// and stop included; both are zero if the sequence ends with no stop.
// Config port: cfg_we with cfg_index 0 frame_start, 1 start codon mask,
// 2 stop codon mask; write only while the block is idle.
// Throughput: one base per cycle while the receiver does not stall.
// A base is held in the input register, and its result, if any, is then
// loaded into the result register, which drives m_tvalid.
// When the receiver stalls with a result pending, s_tready drops once the
// input register is full; nothing is lost or repeated.
// Reset clears all tracking state and loads the default registers
// (frame start 1, ATG start, TAA/TAG/TGA stop). After each tlast the
// tracking state rearms on its own; the registers are kept.
// Depends on orf_pkg, orf_in_stage, orf_tracker, orf_out_stage, assert_macros.svh.
`include "assert_macros.svh"

module open_reading_frame_finder_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [1:0] base, zero padded
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [39:0]                   m_tdata,   // [20:0] start_pos, [39:21] length_codons
  input  logic                          cfg_we,
  input  logic [orf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [orf_pkg::CFG_W-1:0]     cfg_wdata
);

  orf_pkg::orf_item_t   in_item;
  orf_pkg::orf_item_t   held_item;
  orf_pkg::orf_emit_t   emit;
  orf_pkg::orf_result_t out_result;
  logic                 held_valid;
  logic                 room;
  logic                 step;

  assign in_item.base = s_tdata[1:0];
  assign in_item.last = s_tlast;

  // A held word is processed when the result register can take a result.
  assign step = held_valid && room;

  orf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .advance    (room),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  orf_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (held_item),
    .emit      (emit)
  );

  orf_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (step && emit.valid),
    .load_result (emit.result),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_result  (out_result),
    .room        (room)
  );

  assign m_tdata = {out_result.length_codons, out_result.start_pos};

  // No base is processed while a result waits on a stalled receiver.
  `ASSERT_CLK_RST(a_no_step_when_stalled, clk, rst, m_tvalid && !m_tready |-> !step, "step on stall")
  // Every result produced reaches the output register.
  `ASSERT_CLK_RST(a_result_lands, clk, rst, (step && emit.valid) |=> m_tvalid, "result lost")
  // Reset empties the output.
  `ASSERT_CLK(a_reset_clears_out, clk, rst |=> !m_tvalid, "output valid after reset")

endmodule
